>>> sv/srg_pkg.sv
`default_nettype none
package srg_pkg;
    localparam int WORDS = 5;

    localparam logic [31:0] SHA_IV [0:4] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam logic [31:0] PRIME_Q [0:4] = '{
        32'hB156C1F5, 32'h2E4248D5, 32'h4144A5BD, 32'h08241CC7, 32'h903C803F
    };

    typedef enum logic [3:0] {
        ST_COLLECT,
        ST_LOAD,
        ST_ROUND,
        ST_FINISH,
        ST_CMP,
        ST_EMIT,
        ST_SUB,
        ST_ADD
    } state_t;

    function automatic logic [31:0] swap32(input logic [31:0] x);
        swap32 = {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction
endpackage
`default_nettype wire

>>> sv/srg_ram.sv
`default_nettype none
module srg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> sv/srg_round.sv
`default_nettype none
// One SHA-1 compression round on the working variables.
module srg_round
    import srg_pkg::*;
(
    input  wire logic [6:0]   idx,
    input  wire logic [159:0] abcde,
    input  wire logic [31:0]  w,
    output logic      [159:0] abcde_next
);
    logic [31:0] a, b, c, d, e, f, k, t;

    always_comb
    begin
        {e, d, c, b, a} = abcde;
        if (idx < 7'd20)
        begin
            f = (b & c) | (~b & d);
            k = 32'h5A827999;
        end
        else if (idx < 7'd40)
        begin
            f = b ^ c ^ d;
            k = 32'h6ED9EBA1;
        end
        else if (idx < 7'd60)
        begin
            f = (b & c) | (b & d) | (c & d);
            k = 32'h8F1BBCDC;
        end
        else
        begin
            f = b ^ c ^ d;
            k = 32'hCA62C1D6;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w;
        abcde_next = {d, c, {b[1:0], b[31:2]}, a, t};
    end
endmodule
`default_nettype wire

>>> sv/sha1_seeded_random_generator.sv
`default_nettype none
// After the fifth input beat is accepted the block loads the schedule, runs the SHA-1 rounds,
// adds the chaining values and compares with the previous digest before the first result beat.
// A round takes five input beats, the hash, five result beats and, when the seed advances, a
// reduce and an add step; no new input is taken until it is through, and output stalls lengthen it.
// The single shared round unit and the schedule RAM, with one write and one read port, keep it serial.
// Reset: seed and previous digest clear to zero; the word counter returns to word zero.
module sha1_seeded_random_generator
    import srg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // entropy_word
    input  wire logic        s_tuser,  // final_round
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // random_word
    output logic             m_tlast,  // last_word
    output logic             m_tuser   // repeat_fail
);
    state_t state_reg, state_next;

    // The seed, previous digest and working hash are fixed-width 160-bit registers.
    logic [159:0] seed_reg, prev_reg, hv_reg, abcde_reg, abcde_rnd;
    logic [159:0] ent_reg;
    logic [2:0]   wcnt_reg;
    logic [6:0]   idx_reg;
    logic         final_reg, fail_reg;
    logic [159:0] num_reg;
    logic [2:0]   ocnt_reg;

    // The message schedule lives in a 16-entry RAM; the first sixteen words are read a word
    // ahead from its registered read port. A small sliding copy of the last 16 words feeds the expansion XOR.
    logic [31:0]  w_win_reg [0:15];
    logic         ram_we;
    logic [3:0]   ram_waddr, ram_raddr;
    logic [31:0]  ram_wdata, ram_rdata;
    logic [31:0]  w_cur;
    logic [31:0]  w_x;
    logic [31:0]  load_word;

    srg_ram #(.WIDTH(32), .DEPTH(16)) u_sched (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    srg_round u_round (
        .idx(idx_reg), .abcde(abcde_reg), .w(w_cur), .abcde_next(abcde_rnd)
    );

    logic [159:0] seed_x;
    logic [160:0] sub_full;
    logic [160:0] add_full;

    always_comb
    begin
        seed_x = seed_reg ^ ent_reg;
        w_x = w_win_reg[13] ^ w_win_reg[8] ^ w_win_reg[2] ^ w_win_reg[0];
        w_cur = (idx_reg < 7'd16) ? ram_rdata : {w_x[30:0], w_x[31]};
        // Address zero is read at the end of the load phase; each round fetches the next word.
        ram_raddr = (state_reg == ST_LOAD) ? 4'd0 : idx_reg[3:0] + 4'd1;
        ram_we = (state_reg == ST_ROUND) || (state_reg == ST_LOAD && idx_reg < 7'd16);
        ram_waddr = idx_reg[3:0];
        ram_wdata = (state_reg == ST_LOAD) ? load_word : w_cur;
        sub_full = {1'b0, num_reg} - {1'b0, PRIME_Q[4], PRIME_Q[3], PRIME_Q[2],
                                      PRIME_Q[1], PRIME_Q[0]};
        add_full = {1'b0, seed_reg} + {1'b0, num_reg} + 161'd1;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT: if (s_tvalid && wcnt_reg == 3'd4) state_next = ST_LOAD;
            ST_LOAD:    if (idx_reg == 7'd16) state_next = ST_ROUND;
            ST_ROUND:   if (idx_reg == 7'd79) state_next = ST_FINISH;
            ST_FINISH:  state_next = ST_CMP;
            ST_CMP:     state_next = ST_EMIT;
            ST_EMIT:    if (m_tready && ocnt_reg == 3'd4)
                            state_next = (fail_reg || final_reg) ? ST_COLLECT : ST_SUB;
            ST_SUB:     state_next = ST_ADD;
            ST_ADD:     state_next = ST_COLLECT;
            default:    state_next = ST_COLLECT;
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == ST_COLLECT);
        m_tvalid = (state_reg == ST_EMIT);
        m_tlast  = (ocnt_reg == 3'd4);
        m_tuser  = fail_reg;
        m_tdata  = fail_reg ? 32'd0 : hv_reg[ocnt_reg*32 +: 32];
    end

    // Load phase writes the padded block into the schedule RAM one word a cycle
    // while the sliding window is filled; the first sixteen rounds then read that RAM.
    always_comb
    begin
        case (idx_reg[3:0])
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4: load_word = swap32(seed_x[idx_reg[2:0]*32 +: 32]);
            4'd5:    load_word = 32'h80000000;
            4'd15:   load_word = 32'd160;
            default: load_word = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            wcnt_reg  <= 3'd0;
            idx_reg   <= 7'd0;
            ocnt_reg  <= 3'd0;
            seed_reg  <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_COLLECT:
                begin
                    if (s_tvalid)
                    begin
                        ent_reg[wcnt_reg*32 +: 32] <= s_tdata;
                        final_reg <= s_tuser;
                        wcnt_reg <= (wcnt_reg == 3'd4) ? 3'd0 : wcnt_reg + 3'd1;
                    end
                    idx_reg <= 7'd0;
                end
                ST_LOAD:
                begin
                    if (idx_reg < 7'd16)
                    begin
                        w_win_reg[idx_reg[3:0]] <= load_word;
                        idx_reg <= idx_reg + 7'd1;
                    end
                    else
                    begin
                        seed_reg <= seed_x;
                        idx_reg <= 7'd0;
                    end
                    abcde_reg <= {SHA_IV[4], SHA_IV[3], SHA_IV[2], SHA_IV[1], SHA_IV[0]};
                end
                ST_ROUND:
                begin
                    abcde_reg <= abcde_rnd;
                    if (idx_reg >= 7'd16)
                    begin
                        for (int i = 0; i < 15; i++) w_win_reg[i] <= w_win_reg[i+1];
                        w_win_reg[15] <= w_cur;
                    end
                    idx_reg <= idx_reg + 7'd1;
                end
                ST_FINISH:
                begin
                    for (int i = 0; i < 5; i++)
                        hv_reg[i*32 +: 32] <= SHA_IV[i] + abcde_reg[i*32 +: 32];
                end
                ST_CMP:
                begin
                    fail_reg <= (hv_reg == prev_reg);
                    prev_reg <= hv_reg;
                    ocnt_reg <= 3'd0;
                    for (int i = 0; i < 5; i++)
                        num_reg[i*32 +: 32] <= swap32(hv_reg[i*32 +: 32]);
                end
                ST_EMIT:
                begin
                    if (m_tready)
                        ocnt_reg <= (ocnt_reg == 3'd4) ? 3'd0 : ocnt_reg + 3'd1;
                end
                ST_SUB:
                begin
                    if (!sub_full[160]) num_reg <= sub_full[159:0];
                end
                ST_ADD:
                begin
                    seed_reg <= add_full[159:0];
                end
                default: ;
            endcase
        end
    end

    a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> state_reg == ST_EMIT)
        else $error("result beat outside emit phase");
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> !s_tready)
        else $error("input accepted while hashing");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tdata == 32'd0)
        else $error("repeat failure with nonzero data");
endmodule
`default_nettype wire
